FILE: src/ira_pkg.sv
`default_nettype none
package ira_pkg;

  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ONE    = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7a;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR_MINUS,
    S_ERR_ONE,
    S_CONV,
    S_SIGN,
    S_SCAN,
    S_DIGIT
  } state_t;

  // carry handed from one digit cell to the next
  typedef struct packed {
    logic valid;
    logic carry;
  } link_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + dx;
    end else if (d > 6'd35) begin
      digit_char = CHAR_LOWER_Z;
    end else begin
      digit_char = CHAR_LOWER_A + dx - 7'd10;
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/integer_radix_to_ascii_top.sv
`default_nettype none
// A negative request's '-' leaves after the bit-serial pass through the row of digit cells; the
// first digit leaves once leading zeros are shifted out (later for shorter text, after any sign).
// A new number is taken only once the last one's final character is loaded for output, so the
// pass and the digit shift-out set the throughput; a bad radix gives just '-' then '1'.
// Digits then leave one per cycle unless stalled.
// Reset (rst, synchronous): idle, no result pending, radix back to 10.
module integer_radix_to_ascii_top
  import ira_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CHAR_W-1:0]       character,
  output logic                    last
);

  localparam int CNT_W  = $clog2(VALUE_W + MAX_DIGITS);
  localparam int REM_W  = $clog2(MAX_DIGITS + 1);
  // the cycle after the top cell's last bit, so its final carry is seen
  localparam logic [CNT_W-1:0] CONV_END = CNT_W'(VALUE_W + MAX_DIGITS - 1);
  localparam logic [CNT_W-1:0] FEED_END = CNT_W'(VALUE_W);
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(MAX_DIGITS);
  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  state_t             state, state_next;
  logic [RADIX_W-1:0] radix;
  logic [VALUE_W-1:0] mag;
  logic               negative;
  logic [CNT_W-1:0]   cnt;
  logic [REM_W-1:0]   rem;
  logic               overflow;

  logic               in_fire;
  logic               radix_bad;
  logic               can_load;
  logic               load_out;
  logic [CHAR_W-1:0]  char_next;
  logic               last_next;
  logic               top_ready;
  cell_ctrl_t         ctrl;
  link_t              feed;

  link_t              links  [MAX_DIGITS+1];
  logic [DIGIT_W-1:0] digits [MAX_DIGITS+1];
  logic [DIGIT_W-1:0] top_digit;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign can_load  = !out_valid || !out_stall;
  assign top_digit = digits[MAX_DIGITS];
  assign top_ready = (top_digit != '0) || (rem == REM_W'(1)) || overflow;

  assign links[0]  = feed;
  assign digits[0] = '0;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    ira_cell u_cell (
      .clk        (clk),
      .radix      (radix),
      .ctrl       (ctrl),
      .link_in    (links[i]),
      .digit_below(digits[i]),
      .digit      (digits[i+1]),
      .link_out   (links[i+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = radix_bad ? S_ERR_MINUS : S_CONV;
        end
      end
      S_ERR_MINUS: if (can_load) state_next = S_ERR_ONE;
      S_ERR_ONE:   if (can_load) state_next = S_IDLE;
      S_CONV: begin
        if (cnt == CONV_END) begin
          state_next = negative ? S_SIGN : S_SCAN;
        end
      end
      S_SIGN:  if (can_load) state_next = S_SCAN;
      S_SCAN:  if (top_ready) state_next = S_DIGIT;
      S_DIGIT: begin
        if (can_load && rem == REM_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl       = '0;
    feed       = '0;
    load_out   = 1'b0;
    char_next  = CHAR_MINUS;
    last_next  = 1'b0;
    unique case (state)
      S_IDLE: ctrl.clear = in_fire;
      S_ERR_MINUS: load_out = can_load;
      S_ERR_ONE: begin
        load_out  = can_load;
        char_next = CHAR_ONE;
        last_next = 1'b1;
      end
      S_CONV: begin
        feed.valid = (cnt < FEED_END);
        feed.carry = mag[VALUE_W-1];
      end
      S_SIGN: load_out = can_load;
      S_SCAN: ctrl.shift = !top_ready;
      S_DIGIT: begin
        load_out   = can_load;
        ctrl.shift = can_load;
        char_next  = digit_char(top_digit);
        last_next  = (rem == REM_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radix <= RADIX_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      negative <= value[VALUE_W-1];
      if (value == MOST_NEG) begin
        mag <= MOST_POS;
      end else if (value[VALUE_W-1]) begin
        mag <= ~value + VALUE_W'(1);
      end else begin
        mag <= value;
      end
      cnt      <= '0;
      rem      <= REM_INIT;
      overflow <= 1'b0;
    end else begin
      if (state == S_CONV) begin
        mag <= {mag[VALUE_W-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
        // a carry out of the top cell means more digits than cells
        if (links[MAX_DIGITS].valid && links[MAX_DIGITS].carry) begin
          overflow <= 1'b1;
        end
      end
      if (ctrl.shift) begin
        rem <= rem - REM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      character <= char_next;
      last      <= last_next;
    end
  end

  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.clear && ctrl.shift))
    else $error("cell clear and shift together");

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DIGIT) |-> (rem != '0))
    else $error("digit count ran out during shift-out");

  a_first_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && $past(state) == S_SCAN) |-> top_ready)
    else $error("leading zero reached the output");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && can_load && rem == REM_W'(1)) |=> (state == S_IDLE && last))
    else $error("final digit not flagged");

endmodule
`default_nettype wire

FILE: src/ira_cell.sv
`default_nettype none
module ira_cell
  import ira_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [RADIX_W-1:0] radix,
  input  wire cell_ctrl_t         ctrl,
  input  wire link_t              link_in,
  input  wire logic [DIGIT_W-1:0] digit_below,
  output logic [DIGIT_W-1:0]      digit,
  output link_t                   link_out
);

  logic [DIGIT_W:0]   dbl;
  logic               over;
  logic [DIGIT_W-1:0] digit_next;
  link_t              link_next;

  // digit = 2*digit + carry_in, reduced once by radix; digit < radix keeps it below 2*radix
  always_comb begin
    dbl        = {digit, link_in.carry};
    over       = dbl >= {1'b0, radix};
    digit_next = digit;
    link_next  = '0;
    priority if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.shift) begin
      digit_next = digit_below;
    end else if (link_in.valid) begin
      digit_next      = over ? DIGIT_W'(dbl - {1'b0, radix}) : dbl[DIGIT_W-1:0];
      link_next.valid = 1'b1;
      link_next.carry = over;
    end
  end

  always_ff @(posedge clk) begin
    digit    <= digit_next;
    link_out <= link_next;
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
module tb
  import ira_pkg::*;
();

  localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam int HOLD_CYCLES = 800;
  localparam int TAIL_CYCLES = 300;

  class char_board;
    typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              lst;
    } char_t;

    char_t expected_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // text of one number in the given base, most significant digit first
    function void note_request(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] rdx);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digs[MAX_DIGITS_DEF];
      logic [DIGIT_W-1:0] d;
      logic               neg;
      int                 n;
      char_t              e;
      if (rdx < RADIX_MIN || rdx > RADIX_MAX) begin
        e.ch = CHAR_MINUS; e.lst = 1'b0; expected_q.push_back(e);
        e.ch = CHAR_ONE;   e.lst = 1'b1; expected_q.push_back(e);
        return;
      end
      neg = v[VALUE_W-1];
      mag = neg ? ~v + 64'd1 : v;
      if (mag > VAL_MAX) mag = VAL_MAX;
      n = 0;
      do begin
        digs[n] = DIGIT_W'(mag % rdx);
        mag = mag / rdx;
        n++;
      end while (mag != 0 && n < MAX_DIGITS_DEF);
      if (neg) begin
        e.ch = CHAR_MINUS; e.lst = 1'b0; expected_q.push_back(e);
      end
      for (int i = n - 1; i >= 0; i--) begin
        d = digs[i];
        e.ch = (d < 6'd10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_LOWER_A + CHAR_W'(d - 6'd10);
        e.lst = (i == 0);
        expected_q.push_back(e);
      end
    endfunction

    task check_result(input logic [CHAR_W-1:0] ch, input logic lst);
      char_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected character %h last %b", ch, lst));
      end else begin
        e = expected_q.pop_front();
        if (ch !== e.ch) report($sformatf("character %h, want %h", ch, e.ch));
        if (lst !== e.lst) report($sformatf("last %b, want %b (char %h)", lst, e.lst, e.ch));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  character;
  logic               last;

  char_board          board;
  logic [RADIX_W-1:0] radix_now;
  logic [VALUE_W-1:0] directed_q[$];
  bit                 no_idle;
  int                 hold_asks;

  integer_radix_to_ascii_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 15));
  endfunction

  function logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    logic [VALUE_W-1:0] r;
    int                 k;
    r = (radix_now < RADIX_MIN || radix_now > RADIX_MAX) ? 64'd10 : 64'(radix_now);
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 1000));
      1: v = -64'($urandom_range(1, 1000));
      2: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = VAL_MIN;
          2: v = VAL_MAX;
          3: v = -64'd1;
          4: v = 64'd1;
          default: v = VAL_MIN + 64'd1;
        endcase
      end
      3: begin
        // near a power of the base, where the digit count changes
        p = 64'd1;
        k = $urandom_range(1, 63);
        for (int i = 0; i < k; i++) if (p <= VAL_MAX / r) p = p * r;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task set_radix(input logic [RADIX_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radix_now = r;
  endtask

  task wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  task send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    board.note_request(v, radix_now);
  endtask

  task run_phase(input logic [RADIX_W-1:0] r, input bit write_cfg, input int n_rand,
                 input bit burst, input bit long_hold);
    wait_drained();
    if (write_cfg) set_radix(r);
    no_idle = burst;
    if (long_hold) hold_asks++;
    while (directed_q.size() != 0) send_value(directed_q.pop_front());
    repeat (n_rand) send_value(rand_value());
    in_valid <= 1'b0;
  endtask

  // result side: random stall before each character outside burst phases, one long hold on request
  initial begin
    int w;
    int hold_seen;
    out_stall = 1'b0;
    hold_seen = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_asks != hold_seen) begin
        w = HOLD_CYCLES;
        hold_seen = hold_asks;
      end else begin
        w = draw_gap();
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      board.check_result(character, last);
    end
  end

  initial begin
    board     = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    value     = '0;
    radix_now = RADIX_RESET;
    no_idle   = 1'b0;
    hold_asks = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base 10 out of reset
    directed_q = '{64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, VAL_MAX, VAL_MIN,
                   VAL_MIN + 64'd1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
    run_phase(RADIX_RESET, 1'b0, 5, 1'b0, 1'b0);
    directed_q = '{64'd0, VAL_MIN, VAL_MAX};
    run_phase(RADIX_MIN, 1'b1, 6, 1'b0, 1'b0);
    directed_q = '{64'd35, 64'd36, -64'd36, VAL_MIN, VAL_MAX};
    run_phase(RADIX_MAX, 1'b1, 6, 1'b0, 1'b0);
    directed_q = '{64'd0};
    run_phase(6'd0, 1'b1, 4, 1'b0, 1'b0);
    // back-to-back requests while the output is held off
    run_phase(6'd16, 1'b1, 12, 1'b1, 1'b1);
    run_phase(6'd63, 1'b1, 4, 1'b1, 1'b0);
    run_phase(RADIX_W'($urandom_range(3, 35)), 1'b1, 8, 1'b0, 1'b0);
    run_phase(6'd1, 1'b1, 4, 1'b0, 1'b0);
    run_phase(6'd37, 1'b1, 3, 1'b0, 1'b0);
    run_phase(6'd8, 1'b1, 8, 1'b1, 1'b0);
    run_phase(RADIX_MIN, 1'b1, 6, 1'b0, 1'b0);
    run_phase(RADIX_W'($urandom_range(2, 36)), 1'b1, 8, 1'b0, 1'b1);
    run_phase(6'd10, 1'b1, 8, 1'b0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
